[rtl/mi3_pkg.sv]
// Shared widths and constants for the 3x3 matrix inverse pipeline.
package mi3_pkg;

  localparam int N_ELEM    = 9;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 32;
  localparam int ADJ_W     = 33;
  localparam int MAG_W     = 32;
  localparam int DETP_W    = 49;
  localparam int DET_W     = 50;
  localparam int DEN_W     = 48;
  localparam int OUT_W     = 32;
  localparam int FRAC_SH   = 24;
  localparam int Q_W       = 33;
  localparam int DIV_STEPS = Q_W;
  localparam int HI_W      = MAG_W + FRAC_SH - Q_W;
  localparam int QR_W      = Q_W + 1;
  localparam int IN_DATA_W  = N_ELEM * ELEM_W;
  localparam int OUT_DATA_W = N_ELEM * OUT_W;

  localparam logic [QR_W-1:0]  POS_MAX = QR_W'(64'h7FFF_FFFF);
  localparam logic [QR_W-1:0]  NEG_MAX = QR_W'(64'h8000_0000);
  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

[rtl/matrix_inverse_3x3.sv]
// Throughput: one matrix per cycle unless m_tready stalls the output; every stage holds
// its own valid bit and takes a new word whenever its successor moves or it is empty.
// The quotient is a 33-stage restoring divider, one quotient bit per stage.
// Synchronous active-high rst clears all valid bits; data registers are not reset.
module matrix_inverse_3x3 (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2, in_r2c0, in_r2c1, in_r2c2
  input  logic [mi3_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_r0c0, out_r0c1, out_r0c2, out_r1c0, ... out_r2c2
  output logic [mi3_pkg::OUT_DATA_W-1:0]  m_tdata,
  // singular
  output logic                            m_tuser
);
  import mi3_pkg::*;

  // 0 products, 1 cofactors, 2 det terms, 3 det, 4 prep, 5..37 divide, 38 out
  localparam int NS  = DIV_STEPS + 6;
  localparam int PRE = 4;

  logic [NS-1:0] v;
  logic [NS-1:0] ld;

  always_comb begin
    ld[NS-1] = !v[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign s_tready = ld[0];
  assign m_tvalid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= s_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) v[k] <= v[k-1];
      end
    end
  end

  logic signed [ELEM_W-1:0] a [N_ELEM];
  always_comb begin
    for (int i = 0; i < N_ELEM; i++) a[i] = s_tdata[ELEM_W*i +: ELEM_W];
  end

  // stage 0: cofactor products, cofactor = pp - pn
  logic signed [PROD_W-1:0] pp [N_ELEM];
  logic signed [PROD_W-1:0] pn [N_ELEM];
  logic signed [ELEM_W-1:0] e0 [3];
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      pp[0] <= a[8] * a[4];  pn[0] <= a[7] * a[5];
      pp[1] <= a[7] * a[2];  pn[1] <= a[8] * a[1];
      pp[2] <= a[1] * a[5];  pn[2] <= a[2] * a[4];
      pp[3] <= a[6] * a[5];  pn[3] <= a[8] * a[3];
      pp[4] <= a[8] * a[0];  pn[4] <= a[6] * a[2];
      pp[5] <= a[3] * a[2];  pn[5] <= a[5] * a[0];
      pp[6] <= a[7] * a[3];  pn[6] <= a[6] * a[4];
      pp[7] <= a[6] * a[1];  pn[7] <= a[7] * a[0];
      pp[8] <= a[4] * a[0];  pn[8] <= a[3] * a[1];
      e0[0] <= a[0];
      e0[1] <= a[3];
      e0[2] <= a[6];
    end
  end

  // stage 1: cofactors
  logic signed [ADJ_W-1:0]  c1 [N_ELEM];
  logic signed [ELEM_W-1:0] e1 [3];
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int i = 0; i < N_ELEM; i++) begin
        c1[i] <= $signed({pp[i][PROD_W-1], pp[i]}) - $signed({pn[i][PROD_W-1], pn[i]});
      end
      e1 <= e0;
    end
  end

  // stage 2: determinant terms along first column
  logic signed [ADJ_W-1:0]  c2 [N_ELEM];
  logic signed [DETP_W-1:0] dp [3];
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) dp[i] <= e1[i] * c1[i];
      c2 <= c1;
    end
  end

  // stage 3: determinant
  logic signed [ADJ_W-1:0] c3 [N_ELEM];
  logic signed [DET_W-1:0] det;
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      det <= DET_W'(dp[0]) + DET_W'(dp[1]) + DET_W'(dp[2]);
      c3  <= c2;
    end
  end

  // divider pipeline; index 0 is the prep stage
  logic [DEN_W-1:0] dden [DIV_STEPS+1];
  logic             dsing [DIV_STEPS+1];
  logic [DEN_W-1:0] dr   [DIV_STEPS+1][N_ELEM];
  logic [Q_W-1:0]   dq   [DIV_STEPS+1][N_ELEM];
  logic [MAG_W-1:0] dm   [DIV_STEPS+1][N_ELEM];
  logic             dneg [DIV_STEPS+1][N_ELEM];
  logic             dovf [DIV_STEPS+1][N_ELEM];

  logic [DET_W-1:0] det_abs;
  logic [MAG_W-1:0] mag  [N_ELEM];
  logic [HI_W-1:0]  hi   [N_ELEM];
  assign det_abs = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
  always_comb begin
    for (int i = 0; i < N_ELEM; i++) begin
      mag[i] = c3[i][ADJ_W-1] ? MAG_W'(-c3[i]) : c3[i][MAG_W-1:0];
      hi[i]  = mag[i][MAG_W-1 -: HI_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[PRE]) begin
      dden[0]  <= det_abs[DEN_W-1:0];
      dsing[0] <= (det == '0);
      for (int i = 0; i < N_ELEM; i++) begin
        dm[0][i]   <= mag[i];
        dneg[0][i] <= c3[i][ADJ_W-1] ^ det[DET_W-1];
        // quotient would need more than Q_W bits
        dovf[0][i] <= {{(DEN_W-HI_W){1'b0}}, hi[i]} >= det_abs[DEN_W-1:0];
        dr[0][i]   <= {{(DEN_W-HI_W){1'b0}}, hi[i]};
        dq[0][i]   <= '0;
      end
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    localparam int B = DIV_STEPS - k;
    logic             nb [N_ELEM];
    logic [DEN_W:0]   t  [N_ELEM];
    logic             ge [N_ELEM];
    if (B >= FRAC_SH) begin : g_bit
      always_comb begin
        for (int i = 0; i < N_ELEM; i++) nb[i] = dm[k-1][i][B-FRAC_SH];
      end
    end else begin : g_zero
      always_comb begin
        for (int i = 0; i < N_ELEM; i++) nb[i] = 1'b0;
      end
    end
    always_comb begin
      for (int i = 0; i < N_ELEM; i++) begin
        t[i]  = {dr[k-1][i], nb[i]};
        ge[i] = t[i] >= {1'b0, dden[k-1]};
      end
    end
    always_ff @(posedge clk) begin
      if (ld[PRE+k]) begin
        dden[k]  <= dden[k-1];
        dsing[k] <= dsing[k-1];
        for (int i = 0; i < N_ELEM; i++) begin
          dr[k][i]   <= ge[i] ? DEN_W'(t[i] - {1'b0, dden[k-1]}) : t[i][DEN_W-1:0];
          dq[k][i]   <= {dq[k-1][i][Q_W-2:0], ge[i]};
          dm[k][i]   <= dm[k-1][i];
          dneg[k][i] <= dneg[k-1][i];
          dovf[k][i] <= dovf[k-1][i];
        end
      end
    end
  end

  // output stage: round to nearest, saturate, apply sign; zero for a singular matrix
  logic [QR_W-1:0]  qr  [N_ELEM];
  logic [OUT_W-1:0] res [N_ELEM];
  always_comb begin
    for (int i = 0; i < N_ELEM; i++) begin
      qr[i] = {1'b0, dq[DIV_STEPS][i]}
            + QR_W'({dr[DIV_STEPS][i], 1'b0} >= {1'b0, dden[DIV_STEPS]});
      if (dneg[DIV_STEPS][i]) begin
        if (dovf[DIV_STEPS][i] || qr[i] > NEG_MAX) res[i] = SAT_NEG;
        else                                       res[i] = OUT_W'(-qr[i]);
      end else begin
        if (dovf[DIV_STEPS][i] || qr[i] > POS_MAX) res[i] = SAT_POS;
        else                                       res[i] = qr[i][OUT_W-1:0];
      end
      if (dsing[DIV_STEPS]) res[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NS-1]) begin
      for (int i = 0; i < N_ELEM; i++) m_tdata[OUT_W*i +: OUT_W] <= res[i];
      m_tuser <= dsing[DIV_STEPS];
    end
  end

endmodule

[rtl/mi3_checker.sv]
// Port-level checks for the 3x3 matrix inverse, bound to the top level.
module mi3_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mi3_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tuser
);
  import mi3_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("singular word carries nonzero data");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[bench/tb_top.sv]
// Testbench for the 3x3 matrix inverse: scoreboard class plus stream drivers.
`timescale 1ns / 100ps

class inv_scoreboard;
  typedef struct packed {
    logic [mi3_pkg::OUT_DATA_W-1:0] elems;
    logic                           sing;
  } inv_result_t;

  inv_result_t pending_inverses[$];
  int mismatches;
  int checked;
  int singular_seen;
  int saturated_seen;

  function new();
    mismatches = 0;
    checked = 0;
    singular_seen = 0;
    saturated_seen = 0;
  endfunction

  // round(c * 2^24 / d) to nearest, ties away from zero, saturated to 32 bits
  function logic [31:0] scaled_quotient(longint c, longint d);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    logic         neg;
    num = (c < 0) ? 128'(-c) : 128'(c);
    num = num << 24;
    den = (d < 0) ? 128'(-d) : 128'(d);
    neg = (c < 0) != (d < 0);
    q = (2 * num + den) / (2 * den);
    if (neg) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function void note_matrix(logic [mi3_pkg::IN_DATA_W-1:0] word);
    longint a[9];
    longint cof[9];
    longint det;
    inv_result_t r;
    for (int i = 0; i < 9; i++) a[i] = longint'($signed(word[i*16 +: 16]));
    cof[0] =  (a[8] * a[4] - a[7] * a[5]);
    cof[1] = -(a[8] * a[1] - a[7] * a[2]);
    cof[2] =  (a[1] * a[5] - a[2] * a[4]);
    cof[3] = -(a[8] * a[3] - a[6] * a[5]);
    cof[4] =  (a[8] * a[0] - a[6] * a[2]);
    cof[5] = -(a[5] * a[0] - a[3] * a[2]);
    cof[6] =  (a[7] * a[3] - a[6] * a[4]);
    cof[7] = -(a[7] * a[0] - a[6] * a[1]);
    cof[8] =  (a[4] * a[0] - a[3] * a[1]);
    det = a[0] * cof[0] + a[3] * cof[1] + a[6] * cof[2];
    r.elems = '0;
    r.sing = (det == 0);
    if (det != 0)
      for (int i = 0; i < 9; i++) r.elems[i*32 +: 32] = scaled_quotient(cof[i], det);
    pending_inverses.push_back(r);
  endfunction

  function void check_inverse(logic [mi3_pkg::OUT_DATA_W-1:0] elems, logic sing);
    inv_result_t e;
    checked++;
    if (pending_inverses.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: output word with no matrix outstanding");
      return;
    end
    e = pending_inverses.pop_front();
    if (e.sing) singular_seen++;
    for (int i = 0; i < 9; i++)
      if (e.elems[i*32 +: 32] inside {32'h7FFF_FFFF, 32'h8000_0000}) saturated_seen++;
    if (sing !== e.sing) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: word %0d singular exp %0b got %0b", checked, e.sing, sing);
    end
    for (int i = 0; i < 9; i++)
      if (elems[i*32 +: 32] !== e.elems[i*32 +: 32]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: word %0d elem r%0dc%0d exp %h got %h", checked, i / 3, i % 3,
                   e.elems[i*32 +: 32], elems[i*32 +: 32]);
      end
  endfunction
endclass

module tb_top;
  import mi3_pkg::*;

  localparam int LATENCY   = 39;
  localparam int WDOG_MAX  = 5000;
  localparam int HOLD_OFF  = 300;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  inv_scoreboard sb;
  int  src_idle_pct;
  int  snk_idle_pct;
  bit  snk_hold;
  int  stall_cycles;
  int  matrices_sent;

  matrix_inverse_3x3 i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // accept and check at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) sb.note_matrix(s_tdata);
      if (m_tvalid && m_tready) sb.check_inverse(m_tdata, m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WDOG_MAX) begin
          $display("Timeout with %0d outputs outstanding", sb.pending_inverses.size());
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // receiver readiness
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic logic [15:0] pick_elem();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h1000;
      4: return 16'($urandom_range(7)) - 16'd3;
      5, 6: return 16'($signed(16'($urandom_range(16383))) - 16'sd8192);
      default: return 16'($urandom);
    endcase
  endfunction

  // drive one matrix, holding it until accepted; valid drops only on idle cycles
  task automatic send_matrix(logic [IN_DATA_W-1:0] m);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= m;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    matrices_sent++;
  endtask

  function automatic logic [IN_DATA_W-1:0] pack9(int e[9]);
    logic [IN_DATA_W-1:0] w;
    for (int i = 0; i < 9; i++) w[i*16 +: 16] = 16'(e[i]);
    return w;
  endfunction

  task automatic send_random(int n);
    logic [IN_DATA_W-1:0] w;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 9; i++) w[i*16 +: 16] = pick_elem();
      // some rank-deficient matrices: copy a row or clear one
      if ($urandom_range(9) == 0) w[48 +: 48] = w[0 +: 48];
      if ($urandom_range(19) == 0) w[96 +: 48] = '0;
      send_matrix(w);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    snk_hold = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    matrices_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: identity, scaled identity, singular, extremes, near-singular
    send_matrix(pack9('{4096, 0, 0, 0, 4096, 0, 0, 0, 4096}));
    send_matrix(pack9('{-4096, 0, 0, 0, 8192, 0, 0, 0, 2048}));
    send_matrix(pack9('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    send_matrix(pack9('{1, 2, 3, 4, 5, 6, 7, 8, 9}));
    send_matrix(pack9('{1, 0, 0, 0, 1, 0, 0, 0, 1}));
    send_matrix(pack9('{-1, 0, 0, 0, 1, 0, 0, 0, 1}));
    send_matrix(pack9('{32767, 0, 0, 0, 32767, 0, 0, 0, 32767}));
    send_matrix(pack9('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}));
    send_matrix(pack9('{-32768, -32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767}));
    send_matrix(pack9('{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767}));
    send_matrix(pack9('{0, 4096, 0, 4096, 0, 0, 0, 0, 4096}));
    send_matrix(pack9('{3, 0, 0, 0, 3, 0, 0, 0, 3}));
    send_matrix(pack9('{-32768, 32767, 0, 32767, -32768, 0, 0, 0, 1}));
    send_matrix(pack9('{4096, 4096, 0, 4096, 4097, 0, 0, 0, 4096}));
    send_matrix(pack9('{2, 1, 1, 1, 2, 1, 1, 1, 2}));
    send_matrix(pack9('{-1, -1, -1, -1, -1, -1, -1, -1, -1}));

    src_idle_pct = 28; snk_idle_pct = 59;
    send_random(600);
    src_idle_pct = 59; snk_idle_pct = 28;
    send_random(600);
    // long receiver hold-off while the sender keeps offering
    src_idle_pct = 0; snk_idle_pct = 0;
    snk_hold = 1'b1;
    fork
      begin
        repeat (HOLD_OFF) @(negedge clk);
        snk_hold = 1'b0;
      end
      send_random(100);
    join
    send_random(600);
    s_tvalid <= 1'b0;

    while (sb.pending_inverses.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated elements)",
             matrices_sent, sb.checked, sb.singular_seen, sb.saturated_seen);
    $display("Idle mixes: source/sink heavy, swapped, none; one %0d-cycle sink hold-off",
             HOLD_OFF);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
